### rtl/corridor_funnel_smoothing_top_defines.svh
// Assertion macros shared by the corridor funnel checker.
`ifndef CORRIDOR_FUNNEL_SMOOTHING_TOP_DEFINES_SVH
`define CORRIDOR_FUNNEL_SMOOTHING_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/cfs_pkg.sv
// Shared codes, widths and types of the corridor funnel smoother.
package cfs_pkg;

   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int EDGE_IDX_W = 5;
   localparam int PTOL_W     = 16;
   localparam int XTOL_W     = 24;
   localparam int PROD_W     = 64;

   localparam logic [KIND_W-1:0] KIND_SRC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEST = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic CSR_PTOL = 1'b0;
   localparam logic CSR_XTOL = 1'b1;

   typedef struct packed {
      logic go;      // destination taken, start a run
      logic empty;   // no usable corridor, report status only
   } cfs_cmd_type;

endpackage

### rtl/cfs_xmul.sv
// Shared signed multiplier with a registered product.
module cfs_xmul #(
   parameter int DW = 25
) (
   input  logic                           clock,
   input  logic signed [DW-1:0]           mul_a,
   input  logic signed [DW-1:0]           mul_b,
   output logic [cfs_pkg::PROD_W-1:0]     prod
);
   import cfs_pkg::*;

   logic signed [2*DW-1:0] full_w;
   logic [PROD_W-1:0]      prod_in;
   logic [PROD_W-1:0]      prod_ff;

   assign full_w  = mul_a * mul_b;
   // keep the low 64 bits, sign-extended when the product is narrower
   assign prod_in = PROD_W'(full_w);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### rtl/cfs_walk.sv
// Funnel walk sequencer: point store, fetch, side tests, corner buffer, result register.
module cfs_walk #(
   parameter int MAX_EDGES  = 32,
   parameter int COORD_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [cfs_pkg::PTOL_W-1:0]              ptol,
   input  logic [cfs_pkg::XTOL_W-1:0]              xtol,
   input  logic                                    wr_en,
   input  logic [$clog2(2*MAX_EDGES+2)-1:0]        wr_addr,
   input  logic signed [COORD_BITS-1:0]            wr_x,
   input  logic signed [COORD_BITS-1:0]            wr_y,
   input  cfs_pkg::cfs_cmd_type                    cmd,
   input  logic [$clog2(MAX_EDGES+1)-1:0]          cmd_edges,
   output logic                                    busy,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_is_point,
   output logic [cfs_pkg::EDGE_IDX_W-1:0]          rsp_edge_idx,
   output logic signed [COORD_BITS-1:0]            rsp_x,
   output logic signed [COORD_BITS-1:0]            rsp_y,
   output logic [cfs_pkg::STATUS_W-1:0]            rsp_status,
   output logic                                    rsp_last
);
   import cfs_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int DEPTH = 2*MAX_EDGES + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(DEPTH + 8);
   localparam int EW    = $clog2(MAX_EDGES + 1);
   localparam int CW    = $clog2(MAX_EDGES + 1);
   localparam int CBD   = (MAX_EDGES > 1) ? MAX_EDGES - 1 : 1;
   localparam int CBW   = (CBD > 1) ? $clog2(CBD) : 1;
   localparam int DW    = CB + 1;
   localparam int NW    = (DW > PTOL_W) ? DW : PTOL_W;
   localparam int SLOTS = 5;
   localparam int SW    = $clog2(SLOTS);

   localparam logic [SW-1:0] FETCH_LAST = SW'(SLOTS);

   localparam logic [4:0] W_IDLE  = 5'd0;
   localparam logic [4:0] W_OUTER = 5'd1;
   localparam logic [4:0] W_FETCH = 5'd2;
   localparam logic [4:0] W_EMIT  = 5'd3;
   localparam logic [4:0] W_LOOP  = 5'd4;
   localparam logic [4:0] W_NEAR  = 5'd5;
   localparam logic [4:0] W_M0    = 5'd6;
   localparam logic [4:0] W_M1    = 5'd7;
   localparam logic [4:0] W_M2    = 5'd8;
   localparam logic [4:0] W_D0    = 5'd9;
   localparam logic [4:0] W_D1    = 5'd10;
   localparam logic [4:0] W_D2    = 5'd11;
   localparam logic [4:0] W_D3    = 5'd12;
   localparam logic [4:0] W_D4    = 5'd13;
   localparam logic [4:0] W_NEXTQ = 5'd14;
   localparam logic [4:0] W_RD    = 5'd15;
   localparam logic [4:0] W_LD    = 5'd16;
   localparam logic [4:0] W_STAT  = 5'd17;

   localparam logic [1:0] T_BAD = 2'd0;   // root against left-right arm line
   localparam logic [1:0] T_LQ  = 2'd1;   // query against root-left arm
   localparam logic [1:0] T_RQ  = 2'd2;   // query against root-right arm

   // slot places: root, left arm, right arm, query, query two back
   localparam int S_ROOT = 0;
   localparam int S_LEFT = 1;
   localparam int S_RGHT = 2;
   localparam int S_QRY  = 3;
   localparam int S_QPRV = 4;

   function automatic logic near1(input logic signed [CB-1:0] a,
                                  input logic signed [CB-1:0] b,
                                  input logic [PTOL_W-1:0]    t);
      logic signed [DW-1:0] d;
      logic [DW-1:0]        m;
      d = DW'(a) - DW'(b);
      m = d[DW-1] ? DW'(-d) : DW'(d);
      return NW'(m) < NW'(t);
   endfunction

   function automatic logic near2(input logic signed [CB-1:0] ax,
                                  input logic signed [CB-1:0] ay,
                                  input logic signed [CB-1:0] bx,
                                  input logic signed [CB-1:0] by,
                                  input logic [PTOL_W-1:0]    t);
      return near1(ax, bx, t) && near1(ay, by, t);
   endfunction

   function automatic logic signed [DW-1:0] diff(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b);
      return DW'(a) - DW'(b);
   endfunction

   // point store and its registered read
   logic signed [CB-1:0] xmem [DEPTH];
   logic signed [CB-1:0] ymem [DEPTH];
   logic signed [CB-1:0] rd_x_ff, rd_y_ff;
   logic                 rd_oob_ff;
   logic [IW-1:0]        fidx;

   // corner buffer
   logic signed [CB-1:0]    cbx [CBD];
   logic signed [CB-1:0]    cby [CBD];
   logic [EDGE_IDX_W-1:0]   cbe [CBD];
   logic signed [CB-1:0]    cb_rx_ff, cb_ry_ff;
   logic [EDGE_IDX_W-1:0]   cb_re_ff;
   logic                    cb_we;
   logic [EDGE_IDX_W-1:0]   cb_wedge;

   // fetched points
   logic signed [CB-1:0] sx_ff [SLOTS];
   logic signed [CB-1:0] sy_ff [SLOTS];
   logic                 cap;
   logic [SW-1:0]        cap_idx;

   logic [4:0]            st_ff, st_in;
   logic [IW-1:0]         root_ff, root_in, prev_ff, prev_in;
   logic [IW-1:0]         larm_ff, larm_in, rarm_ff, rarm_in;
   logic [IW-1:0]         qry_ff, qry_in, size_ff, size_in;
   logic [EW-1:0]         edges_ff, edges_in;
   logic [CW-1:0]         cnt_ff, cnt_in, oi_ff, oi_in;
   logic                  ev_ff, ev_in;
   logic signed [CB-1:0]  ex_ff, ex_in, ey_ff, ey_in;
   logic [SW-1:0]         fc_ff, fc_in;
   logic                  emitf_ff, emitf_in;
   logic [1:0]            test_ff, test_in;
   logic [PROD_W-1:0]     p1_ff, p1_in, acc_ff, acc_in;
   logic [STATUS_W-1:0]   stat_ff, stat_in;

   logic                  rsp_v_ff, rsp_v_in;
   logic                  rsp_pt_ff, rsp_pt_in;
   logic [EDGE_IDX_W-1:0] rsp_e_ff, rsp_e_in;
   logic signed [CB-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [STATUS_W-1:0]   rsp_s_ff, rsp_s_in;
   logic                  rsp_l_ff, rsp_l_in;
   logic                  rsp_free;

   // shared multiplier
   logic signed [DW-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0]     prod;

   // side-test operands
   logic [SW-1:0]         v1, v2, vp;
   logic signed [DW-1:0]  dx, dy, qx, qy;
   logic signed [DW-1:0]  dxl, dyl, dxr, dyr;
   logic [PROD_W-1:0]     cval, cmag, dr;
   logic                  c_on, c_left, c_right;
   logic [IW-1:0]         edge_w, dest_idx;
   logic                  emit_add, left_side, at_dest;

   cfs_xmul #(.DW(DW)) u_xmul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   always_comb begin
      case (fc_ff)
         3'd0:    fidx = root_ff;
         3'd1:    fidx = larm_ff;
         3'd2:    fidx = rarm_ff;
         3'd3:    fidx = qry_ff;
         default: fidx = qry_ff - IW'(2);
      endcase
   end

   assign cap     = (st_ff == W_FETCH) && (fc_ff != '0);
   assign cap_idx = fc_ff - SW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         xmem[wr_addr] <= wr_x;
         ymem[wr_addr] <= wr_y;
      end
      rd_x_ff   <= xmem[fidx[AW-1:0]];
      rd_y_ff   <= ymem[fidx[AW-1:0]];
      rd_oob_ff <= fidx >= size_ff;
      // points past the corridor read as zero
      for (int i = 0; i < SLOTS; i++) begin
         if (cap && (cap_idx == SW'(i))) begin
            sx_ff[i] <= rd_oob_ff ? '0 : rd_x_ff;
            sy_ff[i] <= rd_oob_ff ? '0 : rd_y_ff;
         end
      end
      if (cb_we) begin
         cbx[cnt_ff[CBW-1:0]] <= sx_ff[S_ROOT];
         cby[cnt_ff[CBW-1:0]] <= sy_ff[S_ROOT];
         cbe[cnt_ff[CBW-1:0]] <= cb_wedge;
      end
      cb_rx_ff <= cbx[oi_ff[CBW-1:0]];
      cb_ry_ff <= cby[oi_ff[CBW-1:0]];
      cb_re_ff <= cbe[oi_ff[CBW-1:0]];
   end

   always_comb begin
      case (test_ff)
         T_BAD:   begin v1 = SW'(S_LEFT); v2 = SW'(S_RGHT); vp = SW'(S_ROOT); end
         T_LQ:    begin v1 = SW'(S_ROOT); v2 = SW'(S_LEFT); vp = SW'(S_QRY);  end
         default: begin v1 = SW'(S_ROOT); v2 = SW'(S_RGHT); vp = SW'(S_QRY);  end
      endcase
   end

   assign dx  = diff(sx_ff[v2], sx_ff[v1]);
   assign dy  = diff(sy_ff[v2], sy_ff[v1]);
   assign qx  = diff(sx_ff[vp], sx_ff[v1]);
   assign qy  = diff(sy_ff[vp], sy_ff[v1]);
   assign dxl = diff(sx_ff[S_LEFT], sx_ff[S_ROOT]);
   assign dyl = diff(sy_ff[S_LEFT], sy_ff[S_ROOT]);
   assign dxr = diff(sx_ff[S_RGHT], sx_ff[S_ROOT]);
   assign dyr = diff(sy_ff[S_RGHT], sy_ff[S_ROOT]);

   always_comb begin
      case (st_ff)
         W_M1:    begin mul_a = dy;  mul_b = qx;  end
         W_D0:    begin mul_a = dxl; mul_b = dxl; end
         W_D1:    begin mul_a = dyl; mul_b = dyl; end
         W_D2:    begin mul_a = dxr; mul_b = dxr; end
         W_D3:    begin mul_a = dyr; mul_b = dyr; end
         default: begin mul_a = dx;  mul_b = qy;  end
      endcase
   end

   assign cval    = p1_ff - prod;
   assign cmag    = cval[PROD_W-1] ? (~cval + PROD_W'(1)) : cval;
   assign c_on    = cmag < PROD_W'(xtol);
   assign c_left  = !c_on && !cval[PROD_W-1] && (cval != '0);
   assign c_right = !c_on && !c_left;
   assign dr      = p1_ff + prod;

   assign edge_w    = (root_ff - IW'(1)) >> 1;
   assign emit_add  = (edge_w + IW'(1)) < IW'(edges_ff);
   assign dest_idx  = size_ff - IW'(1);
   assign at_dest   = qry_ff == dest_idx;
   assign left_side = qry_ff[0];
   assign rsp_free  = !rsp_v_ff || rsp_ready;
   assign cb_wedge  = EDGE_IDX_W'(edge_w);

   always_comb begin
      st_in     = st_ff;
      root_in   = root_ff;
      prev_in   = prev_ff;
      larm_in   = larm_ff;
      rarm_in   = rarm_ff;
      qry_in    = qry_ff;
      size_in   = size_ff;
      edges_in  = edges_ff;
      cnt_in    = cnt_ff;
      oi_in     = oi_ff;
      ev_in     = ev_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      fc_in     = fc_ff;
      emitf_in  = emitf_ff;
      test_in   = test_ff;
      p1_in     = p1_ff;
      acc_in    = acc_ff;
      stat_in   = stat_ff;
      cb_we     = 1'b0;
      rsp_v_in  = rsp_v_ff && !rsp_ready;
      rsp_pt_in = rsp_pt_ff;
      rsp_e_in  = rsp_e_ff;
      rsp_x_in  = rsp_x_ff;
      rsp_y_in  = rsp_y_ff;
      rsp_s_in  = rsp_s_ff;
      rsp_l_in  = rsp_l_ff;

      case (st_ff)
         W_IDLE: begin
            if (cmd.go) begin
               if (cmd.empty) begin
                  stat_in = STATUS_EMPTY;
                  st_in   = W_STAT;
               end else begin
                  edges_in = cmd_edges;
                  size_in  = (IW'(cmd_edges) << 1) + IW'(2);
                  root_in  = '0;
                  cnt_in   = '0;
                  ev_in    = 1'b0;
                  st_in    = W_OUTER;
               end
            end
         end
         W_OUTER: begin
            prev_in = root_ff;
            if (root_ff[0]) begin
               larm_in = root_ff + IW'(2);
               rarm_in = root_ff + IW'(3);
               qry_in  = root_ff + IW'(4);
            end else begin
               larm_in = root_ff + IW'(1);
               rarm_in = root_ff + IW'(2);
               qry_in  = root_ff + IW'(3);
            end
            fc_in    = '0;
            emitf_in = 1'b1;
            st_in    = W_FETCH;
         end
         W_FETCH: begin
            fc_in = fc_ff + SW'(1);
            if (fc_ff == FETCH_LAST) begin
               fc_in = '0;
               st_in = emitf_ff ? W_EMIT : W_NEAR;
            end
         end
         W_EMIT: begin
            // skip the source, the last edge, a full buffer or a repeated corner
            if (root_ff != '0 && emit_add &&
                !(ev_ff && near2(sx_ff[S_ROOT], sy_ff[S_ROOT], ex_ff, ey_ff, ptol)) &&
                cnt_ff < CW'(MAX_EDGES - 1)) begin
               cb_we  = 1'b1;
               ex_in  = sx_ff[S_ROOT];
               ey_in  = sy_ff[S_ROOT];
               ev_in  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
            st_in = W_LOOP;
         end
         W_LOOP: begin
            if (qry_ff < size_ff && root_ff == prev_ff) begin
               fc_in    = '0;
               emitf_in = 1'b0;
               st_in    = W_FETCH;
            end else if (root_ff != prev_ff) begin
               st_in = W_OUTER;
            end else begin
               oi_in = '0;
               st_in = W_RD;
            end
         end
         W_NEAR: begin
            if (near2(sx_ff[S_ROOT], sy_ff[S_ROOT], sx_ff[S_LEFT], sy_ff[S_LEFT], ptol)) begin
               root_in = larm_ff;
               st_in   = W_NEXTQ;
            end else if (near2(sx_ff[S_ROOT], sy_ff[S_ROOT],
                               sx_ff[S_RGHT], sy_ff[S_RGHT], ptol)) begin
               root_in = rarm_ff;
               st_in   = W_NEXTQ;
            end else if (!at_dest &&
                         near2(sx_ff[S_QRY], sy_ff[S_QRY],
                               sx_ff[S_QPRV], sy_ff[S_QPRV], ptol)) begin
               st_in = W_NEXTQ;
            end else begin
               test_in = T_BAD;
               st_in   = W_M0;
            end
         end
         W_M0: st_in = W_M1;
         W_M1: begin
            p1_in = prod;
            st_in = W_M2;
         end
         W_M2: begin
            st_in = W_NEXTQ;
            case (test_ff)
               T_BAD: begin
                  if (c_left) begin
                     if (root_ff != '0) begin
                        // bad funnel away from the source: drop the run
                        stat_in = STATUS_BAD;
                        st_in   = W_STAT;
                     end else begin
                        larm_in = larm_ff + IW'(2);
                        rarm_in = rarm_ff + IW'(2);
                        qry_in  = qry_ff + IW'(1);
                     end
                  end else if (c_on) begin
                     st_in = W_D0;
                  end else begin
                     test_in = T_LQ;
                     st_in   = W_M0;
                  end
               end
               T_LQ: begin
                  if (c_left) begin
                     if (!left_side) root_in = larm_ff;
                     else if (at_dest) root_in = larm_ff;
                  end else begin
                     test_in = T_RQ;
                     st_in   = W_M0;
                  end
               end
               default: begin
                  if (c_right) begin
                     if (left_side) root_in = rarm_ff;
                     else if (at_dest) root_in = rarm_ff;
                  end else if (left_side) begin
                     larm_in = qry_ff;
                  end else begin
                     rarm_in = qry_ff;
                  end
               end
            endcase
         end
         W_D0: st_in = W_D1;
         W_D1: begin
            p1_in = prod;
            st_in = W_D2;
         end
         W_D2: begin
            acc_in = p1_ff + prod;
            st_in  = W_D3;
         end
         W_D3: begin
            p1_in = prod;
            st_in = W_D4;
         end
         W_D4: begin
            // zero-angle funnel: nearer arm becomes the root, ties go right
            root_in = (acc_ff < dr) ? larm_ff : rarm_ff;
            st_in   = W_NEXTQ;
         end
         W_NEXTQ: begin
            qry_in = qry_ff + IW'(1);
            st_in  = W_LOOP;
         end
         W_RD: begin
            if (oi_ff == cnt_ff) begin
               stat_in = STATUS_OK;
               st_in   = W_STAT;
            end else begin
               st_in = W_LD;
            end
         end
         W_LD: begin
            if (rsp_free) begin
               rsp_v_in  = 1'b1;
               rsp_pt_in = 1'b1;
               rsp_e_in  = cb_re_ff;
               rsp_x_in  = cb_rx_ff;
               rsp_y_in  = cb_ry_ff;
               rsp_s_in  = STATUS_OK;
               rsp_l_in  = 1'b0;
               oi_in     = oi_ff + CW'(1);
               st_in     = W_RD;
            end
         end
         W_STAT: begin
            if (rsp_free) begin
               rsp_v_in  = 1'b1;
               rsp_pt_in = 1'b0;
               rsp_e_in  = '0;
               rsp_x_in  = '0;
               rsp_y_in  = '0;
               rsp_s_in  = stat_ff;
               rsp_l_in  = 1'b1;
               st_in     = W_IDLE;
            end
         end
         default: st_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= W_IDLE;
         rsp_v_ff <= 1'b0;
         root_ff  <= '0;
         prev_ff  <= '0;
         larm_ff  <= '0;
         rarm_ff  <= '0;
         qry_ff   <= '0;
         size_ff  <= IW'(DEPTH);
         cnt_ff   <= '0;
         oi_ff    <= '0;
         ev_ff    <= 1'b0;
         fc_ff    <= '0;
         emitf_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         rsp_v_ff <= rsp_v_in;
         root_ff  <= root_in;
         prev_ff  <= prev_in;
         larm_ff  <= larm_in;
         rarm_ff  <= rarm_in;
         qry_ff   <= qry_in;
         size_ff  <= size_in;
         cnt_ff   <= cnt_in;
         oi_ff    <= oi_in;
         ev_ff    <= ev_in;
         fc_ff    <= fc_in;
         emitf_ff <= emitf_in;
      end
      edges_ff  <= edges_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      test_ff   <= test_in;
      p1_ff     <= p1_in;
      acc_ff    <= acc_in;
      stat_ff   <= stat_in;
      rsp_pt_ff <= rsp_pt_in;
      rsp_e_ff  <= rsp_e_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_s_ff  <= rsp_s_in;
      rsp_l_ff  <= rsp_l_in;
   end

   assign busy         = st_ff != W_IDLE;
   assign rsp_valid    = rsp_v_ff;
   assign rsp_is_point = rsp_pt_ff;
   assign rsp_edge_idx = rsp_e_ff;
   assign rsp_x        = rsp_x_ff;
   assign rsp_y        = rsp_y_ff;
   assign rsp_status   = rsp_s_ff;
   assign rsp_last     = rsp_l_ff;

endmodule

### rtl/corridor_funnel_smoothing_top.sv
// Corridor funnel smoother: stream ports, tolerance registers and corridor loading.
// Usage: send a source point, the corridor edges (left and right vertex per beat),
// then a destination point. Source and destination points are written as their beats
// are taken; an edge beat writes its second vertex in the L_EDGE2 state, with req_tready
// low (the point store has one write port). The destination starts the funnel
// walk, during which req_tready stays low. Every query step refetches five points
// through the single store read port, runs the near tests, then up to three side
// tests through the one shared multiplier, the first of them possibly followed by an
// arm-length compare, then advances the query and checks the loop; each new root
// adds an outer pass. Corners are buffered and sent one per W_RD and W_LD pass,
// waiting while rsp_tready is low, then a status beat with tlast. A bad funnel away
// from the source sends only status 1; an empty or overfull corridor only status 2.
// The point store needs no clearing pass after reset.
module corridor_funnel_smoothing_top #(
   parameter int MAX_EDGES  = 32,
   parameter int COORD_BITS = 24
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // req_tdata: ax, ay, bx, by (lowest bits first)
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]             req_tdata,
   // req_tuser: kind
   input  logic [cfs_pkg::KIND_W-1:0]                    req_tuser,
   // rsp_tdata: edge_index, point_x, point_y, status (lowest bits first)
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [((2*COORD_BITS+7+7)/8)*8-1:0]           rsp_tdata,
   // rsp_tuser: is_point
   output logic                                          rsp_tuser,
   output logic                                          rsp_tlast,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic                                          csr_index,
   input  logic [cfs_pkg::XTOL_W-1:0]                    csr_wdata
);
   import cfs_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int DEPTH = 2*MAX_EDGES + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = $clog2(MAX_EDGES + 1);
   localparam int ODW   = ((2*CB+7+7)/8)*8;

   localparam logic [1:0] L_IDLE  = 2'd0;
   localparam logic [1:0] L_EDGE2 = 2'd1;
   localparam logic [1:0] L_BUSY  = 2'd2;

   logic [1:0]           ld_ff, ld_in;
   logic [AW-1:0]        pc_ff, pc_in, pc_eff;
   logic                 ovf_ff, ovf_in;
   logic signed [CB-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [AW-1:0]        wa2_ff, wa2_in;
   logic [PTOL_W-1:0]    ptol_ff;
   logic [XTOL_W-1:0]    xtol_ff;

   logic                 req_acc;
   logic signed [CB-1:0] ax, ay, bx, by;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [CB-1:0] wr_x, wr_y;
   cfs_cmd_type          cmd;
   logic [EW-1:0]        cmd_edges;
   logic                 busy;

   logic                  rsp_is_point, rsp_last;
   logic [EDGE_IDX_W-1:0] rsp_edge_idx;
   logic signed [CB-1:0]  rsp_x, rsp_y;
   logic [STATUS_W-1:0]   rsp_status;

   assign ax = req_tdata[CB-1:0];
   assign ay = req_tdata[2*CB-1:CB];
   assign bx = req_tdata[3*CB-1:2*CB];
   assign by = req_tdata[4*CB-1:3*CB];

   assign req_tready = ld_ff == L_IDLE;
   assign req_acc    = req_tvalid && req_tready;
   assign pc_eff     = (pc_ff == '0) ? AW'(1) : pc_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      ld_in     = ld_ff;
      pc_in     = pc_ff;
      ovf_in    = ovf_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      wa2_in    = wa2_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_x      = ax;
      wr_y      = ay;
      cmd       = '0;
      cmd_edges = (pc_ff == '0) ? '0 : EW'((pc_ff - AW'(1)) >> 1);

      case (ld_ff)
         L_IDLE: begin
            if (req_acc) begin
               case (req_tuser)
                  KIND_SRC: begin
                     wr_en  = 1'b1;
                     pc_in  = AW'(1);
                     ovf_in = 1'b0;
                  end
                  KIND_EDGE: begin
                     if (pc_eff >= AW'(2*MAX_EDGES + 1)) begin
                        // corridor full: drop the edge, mark the run
                        ovf_in = 1'b1;
                        pc_in  = pc_eff;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pc_eff;
                        bx_in   = bx;
                        by_in   = by;
                        wa2_in  = pc_eff + AW'(1);
                        pc_in   = pc_eff + AW'(2);
                        ld_in   = L_EDGE2;
                     end
                  end
                  KIND_DEST: begin
                     cmd.go    = 1'b1;
                     cmd.empty = (cmd_edges == '0) || ovf_ff;
                     wr_en     = !cmd.empty;
                     wr_addr   = pc_ff;
                     pc_in     = '0;
                     ovf_in    = 1'b0;
                     ld_in     = L_BUSY;
                  end
                  default: ;
               endcase
            end
         end
         L_EDGE2: begin
            wr_en   = 1'b1;
            wr_addr = wa2_ff;
            wr_x    = bx_ff;
            wr_y    = by_ff;
            ld_in   = L_IDLE;
         end
         L_BUSY: begin
            if (!busy) ld_in = L_IDLE;
         end
         default: ld_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_ff   <= L_IDLE;
         pc_ff   <= '0;
         ovf_ff  <= 1'b0;
         ptol_ff <= PTOL_W'(1);
         xtol_ff <= XTOL_W'(1);
      end else begin
         ld_ff  <= ld_in;
         pc_ff  <= pc_in;
         ovf_ff <= ovf_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PTOL: ptol_ff <= csr_wdata[PTOL_W-1:0];
               CSR_XTOL: xtol_ff <= csr_wdata;
               default:  ;
            endcase
         end
      end
      bx_ff  <= bx_in;
      by_ff  <= by_in;
      wa2_ff <= wa2_in;
   end

   cfs_walk #(
      .MAX_EDGES  (MAX_EDGES),
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .ptol         (ptol_ff),
      .xtol         (xtol_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_x         (wr_x),
      .wr_y         (wr_y),
      .cmd          (cmd),
      .cmd_edges    (cmd_edges),
      .busy         (busy),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_is_point (rsp_is_point),
      .rsp_edge_idx (rsp_edge_idx),
      .rsp_x        (rsp_x),
      .rsp_y        (rsp_y),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   assign rsp_tdata = ODW'({rsp_status, rsp_y, rsp_x, rsp_edge_idx});
   assign rsp_tuser = rsp_is_point;
   assign rsp_tlast = rsp_last;

endmodule

### rtl/cfs_check.sv
// Port-level checker for the corridor funnel smoother, bound to the top level.
`include "corridor_funnel_smoothing_top_defines.svh"

module cfs_check #(
   parameter int COORD_BITS = 24
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [cfs_pkg::KIND_W-1:0]            req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((2*COORD_BITS+7+7)/8)*8-1:0]   rsp_tdata,
   input logic                                  rsp_tuser,
   input logic                                  rsp_tlast
);
   import cfs_pkg::*;

   logic [STATUS_W-1:0] status_w;

   assign status_w = rsp_tdata[2*COORD_BITS+6:2*COORD_BITS+5];

   `CFS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result beat dropped")
   `CFS_ASSERT_NOW(a_status_beat, rsp_tvalid && rsp_tlast, !rsp_tuser, "tlast on a corner beat")
   `CFS_ASSERT_NOW(a_corner_beat, rsp_tvalid && rsp_tuser, !rsp_tlast && status_w == STATUS_OK, "corner beat carries status")
   `CFS_ASSERT_NEXT(a_dest_busy, req_tvalid && req_tready && req_tuser == KIND_DEST, !req_tready, "input taken during walk")

endmodule

bind corridor_funnel_smoothing_top cfs_check #(.COORD_BITS(COORD_BITS)) u_cfs_check (.*);
